[rtl/core/ircd_pkg.sv]
// ----------------------------------------------------------------------------
// ircd_pkg
// Shared types and constants for the manchester ir frame decoder.
// ----------------------------------------------------------------------------
package ircd_pkg;

  localparam logic [3:0]  FRAME_LEN      = 4'd14;
  localparam logic [3:0]  NIBBLE_BAD     = 4'h8;
  localparam int          QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] HALF_MIN_RST   = 16'd689;
  localparam logic [15:0] HALF_MAX_RST   = 16'd1089;
  localparam logic [15:0] FULL_MIN_RST   = 16'd1578;
  localparam logic [15:0] FULL_MAX_RST   = 16'd1978;
  localparam logic [1:0]  EXP_ADDR_RST   = 2'd0;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } ircd_status_t;

  typedef enum logic [1:0] {
    HALVES_NONE = 2'd0,
    HALVES_ONE  = 2'd1,
    HALVES_TWO  = 2'd2
  } ircd_halves_t;

  typedef enum logic [2:0] {
    CFG_HALF_MIN = 3'd0,
    CFG_HALF_MAX = 3'd1,
    CFG_FULL_MIN = 3'd2,
    CFG_FULL_MAX = 3'd3,
    CFG_EXP_ADDR = 3'd4
  } ircd_cfg_idx_t;

  // classified segment handed from front to back
  typedef struct packed {
    logic         op;
    logic         level;
    ircd_halves_t halves;
  } ircd_cmd_t;

endpackage

[rtl/core/ircd_front.sv]
// ----------------------------------------------------------------------------
// ircd_front
// Holds the timing windows and classifies each segment length.
// ----------------------------------------------------------------------------
module ircd_front
  import ircd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_op,
  input  logic            in_level,
  input  logic [15:0]     in_duration_us,
  output logic            push_valid,
  input  logic            push_ready,
  output ircd_cmd_t       push_cmd,
  output logic [1:0]      exp_addr
);

  logic [15:0] half_min_r;
  logic [15:0] half_max_r;
  logic [15:0] full_min_r;
  logic [15:0] full_max_r;
  logic [1:0]  exp_addr_r;
  logic        in_half;
  logic        in_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_min_r <= HALF_MIN_RST;
      half_max_r <= HALF_MAX_RST;
      full_min_r <= FULL_MIN_RST;
      full_max_r <= FULL_MAX_RST;
      exp_addr_r <= EXP_ADDR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HALF_MIN: half_min_r <= cfg_data;
        CFG_HALF_MAX: half_max_r <= cfg_data;
        CFG_FULL_MIN: full_min_r <= cfg_data;
        CFG_FULL_MAX: full_max_r <= cfg_data;
        CFG_EXP_ADDR: exp_addr_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // half window wins where the two overlap
  assign in_half = (in_duration_us >= half_min_r) && (in_duration_us <= half_max_r);
  assign in_full = (in_duration_us >= full_min_r) && (in_duration_us <= full_max_r);

  always_comb begin
    push_cmd.op    = in_op;
    push_cmd.level = in_level;
    if (in_half) begin
      push_cmd.halves = HALVES_ONE;
    end else if (in_full) begin
      push_cmd.halves = HALVES_TWO;
    end else begin
      push_cmd.halves = HALVES_NONE;
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign exp_addr   = exp_addr_r;

endmodule

[rtl/core/ircd_queue.sv]
// ----------------------------------------------------------------------------
// ircd_queue
// Small register queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module ircd_queue
  import ircd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  ircd_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output ircd_cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ircd_cmd_t          slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

[rtl/core/ircd_back.sv]
// ----------------------------------------------------------------------------
// ircd_back
// Frame engine: pairs half-bits, assembles 14 bits, checks the frame and
// drives the registered result.
// ----------------------------------------------------------------------------
module ircd_back
  import ircd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  ircd_cmd_t         pop_cmd,
  input  logic [1:0]        exp_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_toggle,
  output logic [1:0]        out_address,
  output logic              out_frame_kind,
  output logic [7:0]        out_payload,
  output logic signed [3:0] out_move_x,
  output logic signed [3:0] out_move_y
);

  logic [13:0]  frame_bits_r, frame_bits_nxt;
  logic [3:0]   bit_count_r, bit_count_nxt;
  logic         half_pending_r, half_pending_nxt;
  logic         first_level_r, first_level_nxt;

  logic         out_valid_r;
  ircd_status_t status_r, status_nxt;
  logic         toggle_r, toggle_nxt;
  logic [1:0]   address_r, address_nxt;
  logic         frame_kind_r, frame_kind_nxt;
  logic [7:0]   payload_r, payload_nxt;
  logic [3:0]   move_x_r, move_x_nxt;
  logic [3:0]   move_y_r, move_y_nxt;

  logic         do_pop;
  logic         live;
  logic         frame_ok;
  logic [1:0]   addr_w;
  logic [7:0]   pay_w;

  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    frame_bits_nxt   = frame_bits_r;
    bit_count_nxt    = bit_count_r;
    half_pending_nxt = half_pending_r;
    first_level_nxt  = first_level_r;
    status_nxt       = ST_BUSY;
    toggle_nxt       = 1'b0;
    address_nxt      = '0;
    frame_kind_nxt   = 1'b0;
    payload_nxt      = '0;
    move_x_nxt       = '0;
    move_y_nxt       = '0;
    live             = 1'b1;
    frame_ok         = 1'b0;
    addr_w           = '0;
    pay_w            = '0;
    if (pop_cmd.op) begin
      frame_bits_nxt   = '0;
      bit_count_nxt    = '0;
      half_pending_nxt = 1'b0;
      first_level_nxt  = 1'b0;
    end else if (bit_count_r >= FRAME_LEN || pop_cmd.halves == HALVES_NONE) begin
      status_nxt = ST_ERROR;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (live && (k == 0 || pop_cmd.halves == HALVES_TWO)) begin
          if (!half_pending_nxt) begin
            first_level_nxt  = pop_cmd.level;
            half_pending_nxt = 1'b1;
          end else if (first_level_nxt == pop_cmd.level) begin
            status_nxt = ST_ERROR;
            live       = 1'b0;
          end else begin
            // high then low is a one, so the bit equals the first half
            frame_bits_nxt[bit_count_nxt] = first_level_nxt;
            bit_count_nxt    = bit_count_nxt + 1'b1;
            half_pending_nxt = 1'b0;
            if (bit_count_nxt == FRAME_LEN) begin
              live = 1'b0;
              // rest of a full segment is dropped once the frame is complete
              addr_w = {frame_bits_nxt[3], frame_bits_nxt[4]};
              for (int i = 0; i < 8; i++) begin
                pay_w[7-i] = frame_bits_nxt[6+i];
              end
              frame_ok = frame_bits_nxt[0] && frame_bits_nxt[1] && (addr_w == exp_addr);
              if (frame_bits_nxt[5]) begin
                frame_ok = frame_ok && (pay_w[3:0] != NIBBLE_BAD)
                                    && (pay_w[7:4] != NIBBLE_BAD);
              end else begin
                frame_ok = frame_ok && (pay_w inside {[8'd0:8'd12], [8'd16:8'd31]});
              end
              if (frame_ok) begin
                status_nxt     = ST_DONE;
                toggle_nxt     = frame_bits_nxt[2];
                address_nxt    = addr_w;
                frame_kind_nxt = frame_bits_nxt[5];
                payload_nxt    = pay_w;
                if (frame_bits_nxt[5]) begin
                  move_x_nxt = pay_w[3:0];
                  move_y_nxt = pay_w[7:4];
                end
              end else begin
                status_nxt = ST_ERROR;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r   <= '0;
      bit_count_r    <= '0;
      half_pending_r <= 1'b0;
      first_level_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (do_pop) begin
        frame_bits_r   <= frame_bits_nxt;
        bit_count_r    <= bit_count_nxt;
        half_pending_r <= half_pending_nxt;
        first_level_r  <= first_level_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      status_r     <= status_nxt;
      toggle_r     <= toggle_nxt;
      address_r    <= address_nxt;
      frame_kind_r <= frame_kind_nxt;
      payload_r    <= payload_nxt;
      move_x_r     <= move_x_nxt;
      move_y_r     <= move_y_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_toggle     = toggle_r;
  assign out_address    = address_r;
  assign out_frame_kind = frame_kind_r;
  assign out_payload    = payload_r;
  assign out_move_x     = move_x_r;
  assign out_move_y     = move_y_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= FRAME_LEN)
    else $error("bit count past frame length");

  a_pending_full: assert property (@(posedge clk) disable iff (!rst_n)
    half_pending_r |-> (bit_count_r < FRAME_LEN))
    else $error("half pending on a full frame");

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_DONE) |-> (bit_count_r == FRAME_LEN))
    else $error("frame done without fourteen bits");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_DONE) |->
      (payload_r == '0 && address_r == '0 && !toggle_r && !frame_kind_r))
    else $error("fields set on a result that is not done");

  a_move_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !frame_kind_r) |-> (move_x_r == '0 && move_y_r == '0))
    else $error("movement nibbles on a command frame");

endmodule

[rtl/core/rc5_style_ir_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc5_style_ir_frame_decoder
// Manchester ir frame decoder: segment classifier, queue and frame engine.
// ----------------------------------------------------------------------------
// Each input transaction is one line segment (level and length in us) or a
// clear op. Every input transaction gives exactly one result transaction:
// busy while a frame is being gathered, done with the decoded fields once
// fourteen bits pass the start, address and payload checks, or error.
// The front compares the length against four window registers and pushes
// the classified segment into a two-entry queue; the back pairs half-bits,
// stores the frame and writes the result into an output register.
// Throughput is one transaction per cycle while the receiver takes results;
// an accepted input is written into a queue entry at the accepting edge, and
// the back later pops that entry into the output register.
// If the receiver stalls, the output register holds and the queue absorbs
// two more segments before in_ready drops. cfg writes are taken every cycle
// and should only be issued with no transaction in flight.
// Synchronous reset loads the default windows and address zero, empties the
// queue and clears the frame state; the decoder is ready the cycle after.
// ----------------------------------------------------------------------------
module rc5_style_ir_frame_decoder
  import ircd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic              in_level,
  input  logic [15:0]       in_duration_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_toggle,
  output logic [1:0]        out_address,
  output logic              out_frame_kind,
  output logic [7:0]        out_payload,
  output logic signed [3:0] out_move_x,
  output logic signed [3:0] out_move_y
);

  logic      push_valid;
  logic      push_ready;
  ircd_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  ircd_cmd_t pop_cmd;
  logic [1:0] exp_addr;

  ircd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_level       (in_level),
    .in_duration_us (in_duration_us),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd),
    .exp_addr       (exp_addr)
  );

  ircd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ircd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .exp_addr       (exp_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_toggle     (out_toggle),
    .out_address    (out_address),
    .out_frame_kind (out_frame_kind),
    .out_payload    (out_payload),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y)
  );

endmodule
